// ===== design/str_pkg.sv =====
// ----------------------------------------------------------------------------
// str_pkg
// Shared types and constants of the trapezoidal stepper ramp generator.
// ----------------------------------------------------------------------------
package str_pkg;

    localparam int DelayBits = 16;
    localparam logic [31:0] DelayMask = 32'((64'd1 << DelayBits) - 64'd1);

    localparam int DvdBits = 48;
    localparam int DvsBits = 34;

    localparam logic [31:0] Recip10      = 32'hCCCC_CCCD;
    localparam int          Recip10Shift = 35;

    localparam logic [1:0] PH_STOP  = 2'd0;
    localparam logic [1:0] PH_ACCEL = 2'd1;
    localparam logic [1:0] PH_DECEL = 2'd2;
    localparam logic [1:0] PH_RUN   = 2'd3;

    localparam logic [1:0] CFG_SPEED_TIME = 2'd0;
    localparam logic [1:0] CFG_C0_FREQ    = 2'd1;
    localparam logic [1:0] CFG_C0_SQ      = 2'd2;
    localparam logic [1:0] CFG_ACCEL_LIM  = 2'd3;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic done;
    } t_alu_rsp;

endpackage

// ===== design/str_alu.sv =====
// ----------------------------------------------------------------------------
// str_alu
// Shared arithmetic unit: registered 32x32 multiply, restoring 48/34
// division one bit per cycle, 64-bit integer square root two bits per cycle.
// ----------------------------------------------------------------------------
module str_alu (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  str_pkg::t_alu_req               i_req,
    input  logic [63:0]                     i_opa,
    input  logic [str_pkg::DvsBits-1:0]     i_opb,
    output str_pkg::t_alu_rsp               o_rsp,
    output logic [63:0]                     o_res,
    output logic [str_pkg::DvsBits-1:0]     o_rem
);

    typedef enum logic [1:0] {
        A_IDLE,
        A_DIV,
        A_SQRT
    } t_state;

    t_state                         r_state;
    str_pkg::t_alu_op               r_op;
    logic [5:0]                     r_cnt;
    logic                           r_done;
    logic [63:0]                    r_a;
    logic [63:0]                    r_b;
    logic [63:0]                    r_bit;
    logic [str_pkg::DvsBits-1:0]    r_dvs;
    logic [str_pkg::DvsBits-1:0]    r_rem;

    logic [str_pkg::DvsBits:0]      n_rem_sh;
    logic [str_pkg::DvsBits:0]      n_trial;
    logic [63:0]                    n_sum;

    assign n_rem_sh = {r_rem, r_a[str_pkg::DvdBits-1]};
    assign n_trial  = n_rem_sh - {1'b0, r_dvs};
    assign n_sum    = r_b + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
            r_op    <= str_pkg::ALU_MUL;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_op <= i_req.op;
                        unique case (i_req.op)
                            str_pkg::ALU_MUL: begin
                                r_b    <= i_opa[31:0] * i_opb[31:0];
                                r_done <= 1'b1;
                            end
                            str_pkg::ALU_DIV: begin
                                r_a     <= {16'd0, i_opa[str_pkg::DvdBits-1:0]};
                                r_rem   <= '0;
                                r_dvs   <= i_opb;
                                r_cnt   <= 6'(str_pkg::DvdBits - 1);
                                r_state <= A_DIV;
                            end
                            str_pkg::ALU_SQRT: begin
                                r_a     <= i_opa;
                                r_b     <= '0;
                                r_bit   <= 64'd1 << 62;
                                r_cnt   <= 6'd31;
                                r_state <= A_SQRT;
                            end
                            default: ;
                        endcase
                    end
                end
                A_DIV: begin
                    if (!n_trial[str_pkg::DvsBits]) begin
                        r_rem <= n_trial[str_pkg::DvsBits-1:0];
                    end else begin
                        r_rem <= n_rem_sh[str_pkg::DvsBits-1:0];
                    end
                    r_a[str_pkg::DvdBits-1:0] <=
                        {r_a[str_pkg::DvdBits-2:0], ~n_trial[str_pkg::DvsBits]};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end
                end
                A_SQRT: begin
                    if (r_a >= n_sum) begin
                        r_a <= r_a - n_sum;
                        r_b <= (r_b >> 1) + r_bit;
                    end else begin
                        r_b <= r_b >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_res = (r_op == str_pkg::ALU_DIV) ?
                   {16'd0, r_a[str_pkg::DvdBits-1:0]} : r_b;
    assign o_rem = r_rem;

endmodule

// ===== design/stepper_trapezoid_ramp.sv =====
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp
// Trapezoidal stepper speed profile: plans moves, steps the delay recurrence.
//
//   port group   dir  payload (lowest bit up)
//   s_axis       in   tuser: kind; tdata: move_steps, accel_rate, decel_rate,
//                     top_speed, hold_run
//   m_axis       out  tdata: accepted, compare_offset, step_done, direction,
//                     position, phase, moving, pulse_total
//   i_cfg_*      in   register write: index, 32-bit data
//
// A move command runs four divisions, a fifth when the deceleration split needs
// its own, one square root and the multiplies in the shared unit; a ramp event
// runs one division, other events none. Input ready only while idle; a full
// result register holds the sequencer until m_axis takes it. Reset is
// synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [87:0]   s_axis_tdata,   // move_steps, accel_rate, decel_rate, top_speed, hold_run
    input  logic          s_axis_tuser,   // kind
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [103:0]  m_axis_tdata,   // accepted, compare_offset, step_done, direction,
                                          // position, phase, moving, pulse_total
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_addr,
    input  logic [31:0]   i_cfg_wdata
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISP, ST_LIM_MUL, ST_LIM_DIV, ST_MIN_DIV, ST_Q_DIV, ST_F_MUL,
        ST_X_MUL, ST_SQRT, ST_C0_DIV, ST_S2_MUL, ST_SMAX_DIV, ST_MD_MUL,
        ST_ALIM_DIV, ST_DM_MUL, ST_DM_DIV, ST_COMMIT, ST_RAMP_DIV, ST_OUT
    } t_state;

    t_state r_state;
    logic   r_wait;

    logic [31:0] r_stc, r_c0sq;
    logic [15:0] r_c0f, r_alc;

    logic        r_kind, r_hold;
    logic [31:0] r_raw;
    logic [15:0] r_acc, r_dec, r_spd;

    logic [63:0] r_t0;
    logic [31:0] r_t1, r_lim, r_mind, r_c0, r_smax;
    logic [47:0] r_dmag;

    logic [1:0]           r_phase;
    logic                 r_dir, r_half, r_busy;
    logic [31:0]          r_cur, r_min, r_dstart, r_dsteps, r_rc, r_remr;
    logic [31:0]          r_steps, r_pos, r_total;
    logic [str_pkg::DelayBits-1:0] r_last;

    logic        r_oacc, r_ostep;
    logic [30:0] r_off;
    logic        r_otv;
    logic [103:0] r_odata;

    str_pkg::t_alu_req              alu_req;
    str_pkg::t_alu_rsp              alu_rsp;
    logic [63:0]                    alu_a, alu_res;
    logic [str_pkg::DvsBits-1:0]    alu_b, alu_rem;

    logic [31:0] n_mag;
    logic [34:0] n_m;
    logic [str_pkg::DvsBits-1:0] n_abs_m;
    logic [33:0] n_d;
    logic [31:0] n_nd, n_rsat, n_alim, n_steps1, n_c0sel, n_div10;
    logic        n_arith;

    assign n_mag   = r_raw[31] ? (32'd0 - r_raw) : r_raw;
    assign n_m     = {{3{r_rc[31]}}, r_rc} * 35'd4 + 35'd1;
    assign n_abs_m = r_rc[31] ? 34'(35'd0 - n_m) : n_m[33:0];
    assign n_d     = {1'b0, r_cur, 1'b0} + {2'b00, r_remr};
    assign n_nd    = (r_rc[31] ? (r_cur + alu_res[31:0]) : (r_cur - alu_res[31:0]))
                     & str_pkg::DelayMask;
    assign n_rsat  = (alu_rem[33:32] != 2'b00) ? 32'hFFFF_FFFF : alu_rem[31:0];
    assign n_alim  = (alu_res == 64'd0) ? 32'd1 : alu_res[31:0];
    assign n_steps1 = r_steps + 32'd1;
    assign n_c0sel = (r_c0 <= r_mind) ? r_mind : r_c0;
    assign n_div10 = 32'(alu_res >> str_pkg::Recip10Shift);

    always_comb begin
        n_arith = 1'b1;
        alu_req.op = str_pkg::ALU_DIV;
        alu_a = '0;
        alu_b = '0;
        unique case (r_state)
            ST_LIM_MUL:  begin alu_req.op = str_pkg::ALU_MUL; alu_a = 64'(r_alc);
                               alu_b = 34'(r_acc); end
            ST_LIM_DIV:  begin alu_req.op = str_pkg::ALU_MUL; alu_a = r_t0;
                               alu_b = 34'(str_pkg::Recip10); end
            ST_MIN_DIV:  begin alu_a = 64'(r_stc); alu_b = 34'(r_spd); end
            ST_Q_DIV:    begin alu_a = 64'(r_c0sq); alu_b = 34'(r_acc); end
            ST_F_MUL:    begin alu_req.op = str_pkg::ALU_MUL; alu_a = 64'(r_c0f);
                               alu_b = 34'(r_c0f); end
            ST_X_MUL:    begin alu_req.op = str_pkg::ALU_MUL; alu_a = 64'(r_t1);
                               alu_b = 34'(r_t0[31:0]); end
            ST_SQRT:     begin alu_req.op = str_pkg::ALU_SQRT; alu_a = r_t0; end
            ST_C0_DIV:   begin alu_req.op = str_pkg::ALU_MUL; alu_a = r_t0;
                               alu_b = 34'(str_pkg::Recip10); end
            ST_S2_MUL:   begin alu_req.op = str_pkg::ALU_MUL; alu_a = 64'(r_spd);
                               alu_b = 34'(r_spd); end
            ST_SMAX_DIV: begin alu_a = r_t0; alu_b = 34'(r_lim); end
            ST_MD_MUL:   begin alu_req.op = str_pkg::ALU_MUL; alu_a = 64'(n_mag);
                               alu_b = 34'(r_dec); end
            ST_ALIM_DIV: begin alu_a = r_t0; alu_b = 34'(r_acc) + 34'(r_dec); end
            ST_DM_MUL:   begin alu_req.op = str_pkg::ALU_MUL; alu_a = 64'(r_smax);
                               alu_b = 34'(r_acc); end
            ST_DM_DIV:   begin alu_a = r_t0; alu_b = 34'(r_dec); end
            ST_RAMP_DIV: begin alu_a = 64'(n_d); alu_b = n_abs_m; end
            default:     n_arith = 1'b0;
        endcase
        alu_req.start = n_arith && !r_wait;
    end

    str_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_opa   (alu_a),
        .i_opb   (alu_b),
        .o_rsp   (alu_rsp),
        .o_res   (alu_res),
        .o_rem   (alu_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= 1'b0;
            r_otv   <= 1'b0;
            r_stc   <= 32'd1000000;
            r_c0f   <= 16'd676;
            r_c0sq  <= 32'd6283;
            r_alc   <= 16'd63;
            r_phase <= str_pkg::PH_STOP;
            r_dir   <= 1'b0;
            r_cur   <= '0;
            r_min   <= '0;
            r_dstart <= '0;
            r_dsteps <= '0;
            r_rc    <= '0;
            r_remr  <= '0;
            r_steps <= '0;
            r_last  <= '0;
            r_half  <= 1'b0;
            r_pos   <= '0;
            r_total <= '0;
            r_busy  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    str_pkg::CFG_SPEED_TIME: r_stc  <= i_cfg_wdata;
                    str_pkg::CFG_C0_FREQ:    r_c0f  <= i_cfg_wdata[15:0];
                    str_pkg::CFG_C0_SQ:      r_c0sq <= i_cfg_wdata;
                    str_pkg::CFG_ACCEL_LIM:  r_alc  <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (m_axis_tready) begin
                r_otv <= 1'b0;
            end
            if (alu_req.start) begin
                r_wait <= 1'b1;
            end
            if (alu_rsp.done) begin
                r_wait <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_kind  <= s_axis_tuser;
                        r_raw   <= s_axis_tdata[31:0];
                        r_acc   <= s_axis_tdata[47:32];
                        r_dec   <= s_axis_tdata[63:48];
                        r_spd   <= s_axis_tdata[79:64];
                        r_hold  <= s_axis_tdata[80];
                        r_state <= ST_DISP;
                    end
                end
                ST_DISP: begin
                    r_oacc  <= 1'b0;
                    r_ostep <= 1'b0;
                    r_off   <= '0;
                    r_state <= ST_OUT;
                    if (!r_kind) begin
                        if (!r_busy) begin
                            if (n_mag == 32'd0) begin
                                r_dir  <= r_raw[31];
                                r_busy <= 1'b1;
                                r_oacc <= 1'b1;
                                r_off  <= r_cur[31:1];
                            end else if (n_mag == 32'd1) begin
                                r_rc    <= 32'hFFFF_FFFF;
                                r_phase <= str_pkg::PH_DECEL;
                                r_cur   <= 32'd1000;
                                r_dir   <= r_raw[31];
                                r_busy  <= 1'b1;
                                r_oacc  <= 1'b1;
                                r_off   <= 31'd500;
                            end else if (r_spd != 16'd0 && r_acc != 16'd0 &&
                                         r_dec != 16'd0) begin
                                r_state <= ST_LIM_MUL;
                            end
                        end
                    end else if (r_busy) begin
                        r_off  <= r_cur[31:1];
                        r_half <= ~r_half;
                        if (r_half) begin
                            case (r_phase) inside
                                str_pkg::PH_STOP: begin
                                    r_steps <= '0;
                                    r_remr  <= '0;
                                    r_busy  <= 1'b0;
                                end
                                str_pkg::PH_RUN: begin
                                    if (!r_hold) begin
                                        r_total <= r_total + 32'd1;
                                        r_steps <= n_steps1;
                                        r_pos   <= r_dir ? r_pos - 32'd1 : r_pos + 32'd1;
                                        r_ostep <= 1'b1;
                                        if (n_steps1 >= r_dstart) begin
                                            r_rc    <= r_dsteps;
                                            r_cur   <= 32'(r_last);
                                            r_phase <= str_pkg::PH_DECEL;
                                        end else begin
                                            r_cur <= r_min & str_pkg::DelayMask;
                                        end
                                    end
                                end
                                str_pkg::PH_ACCEL, str_pkg::PH_DECEL: begin
                                    r_total <= r_total + 32'd1;
                                    r_steps <= n_steps1;
                                    r_pos   <= r_dir ? r_pos - 32'd1 : r_pos + 32'd1;
                                    r_ostep <= 1'b1;
                                    r_rc    <= r_rc + 32'd1;
                                    r_state <= ST_RAMP_DIV;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                ST_LIM_MUL: if (alu_rsp.done) begin r_t0 <= alu_res; r_state <= ST_LIM_DIV; end
                ST_LIM_DIV: begin
                    if (alu_rsp.done) begin
                        r_lim   <= n_div10;
                        r_state <= (n_div10 == 32'd0) ? ST_OUT : ST_MIN_DIV;
                    end
                end
                ST_MIN_DIV: if (alu_rsp.done) begin r_mind <= alu_res[31:0];
                                r_state <= ST_Q_DIV; end
                ST_Q_DIV:   if (alu_rsp.done) begin r_t0 <= alu_res; r_state <= ST_F_MUL; end
                ST_F_MUL:   if (alu_rsp.done) begin r_t1 <= alu_res[31:0];
                                r_state <= ST_X_MUL; end
                ST_X_MUL:   if (alu_rsp.done) begin r_t0 <= alu_res; r_state <= ST_SQRT; end
                ST_SQRT:    if (alu_rsp.done) begin r_t0 <= alu_res; r_state <= ST_C0_DIV; end
                ST_C0_DIV:  if (alu_rsp.done) begin r_c0 <= n_div10;
                                r_state <= ST_S2_MUL; end
                ST_S2_MUL:  if (alu_rsp.done) begin r_t0 <= alu_res; r_state <= ST_SMAX_DIV; end
                ST_SMAX_DIV: begin
                    if (alu_rsp.done) begin
                        r_smax  <= (alu_res == 64'd0) ? 32'd1 : alu_res[31:0];
                        r_state <= ST_MD_MUL;
                    end
                end
                ST_MD_MUL:  if (alu_rsp.done) begin r_t0 <= alu_res; r_state <= ST_ALIM_DIV; end
                ST_ALIM_DIV: begin
                    if (alu_rsp.done) begin
                        if (n_alim <= r_smax) begin
                            r_dmag  <= 48'(n_mag - n_alim);
                            r_state <= ST_COMMIT;
                        end else begin
                            r_state <= ST_DM_MUL;
                        end
                    end
                end
                ST_DM_MUL:  if (alu_rsp.done) begin r_t0 <= alu_res; r_state <= ST_DM_DIV; end
                ST_DM_DIV: begin
                    if (alu_rsp.done) begin
                        r_dmag  <= (alu_res[47:0] == 48'd0) ? 48'd1 : alu_res[47:0];
                        r_state <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    r_min    <= r_mind;
                    r_dsteps <= 32'd0 - r_dmag[31:0];
                    r_dstart <= n_mag - r_dmag[31:0];
                    r_cur    <= n_c0sel;
                    if (r_c0 <= r_mind) begin
                        r_last  <= r_mind[str_pkg::DelayBits-1:0];
                        r_phase <= str_pkg::PH_RUN;
                    end else begin
                        r_phase <= str_pkg::PH_ACCEL;
                    end
                    r_rc    <= '0;
                    r_dir   <= r_raw[31];
                    r_busy  <= 1'b1;
                    r_oacc  <= 1'b1;
                    r_off   <= n_c0sel[31:1];
                    r_state <= ST_OUT;
                end
                ST_RAMP_DIV: begin
                    if (alu_rsp.done) begin
                        r_cur   <= n_nd;
                        r_remr  <= n_rsat;
                        r_state <= ST_OUT;
                        if (r_phase == str_pkg::PH_ACCEL) begin
                            if (r_steps >= r_dstart) begin
                                r_rc    <= r_dsteps;
                                r_phase <= str_pkg::PH_DECEL;
                            end else if (n_nd <= r_min) begin
                                r_last  <= n_nd[str_pkg::DelayBits-1:0];
                                r_cur   <= r_min & str_pkg::DelayMask;
                                r_remr  <= '0;
                                r_phase <= str_pkg::PH_RUN;
                            end
                        end else if (!r_rc[31]) begin
                            r_phase <= str_pkg::PH_STOP;
                        end
                    end
                end
                ST_OUT: begin
                    if (!r_otv || m_axis_tready) begin
                        r_otv   <= 1'b1;
                        r_odata <= {3'd0, r_total, r_busy, r_phase, r_pos, r_dir,
                                    r_ostep, r_off, r_oacc};
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_otv;
    assign m_axis_tdata  = r_odata;

endmodule

// ===== design/str_chk.sv =====
// ----------------------------------------------------------------------------
// str_chk
// Port-level checks of the stepper ramp generator, bound to the top level.
// ----------------------------------------------------------------------------
module str_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [103:0]  m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken twice in a row");

    a_acc_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[68] && !m_axis_tdata[32])
        else $error("accepted command without motion");

    a_step_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[68])
        else $error("step counted while idle");

endmodule

bind stepper_trapezoid_ramp str_chk u_str_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Regression for the trapezoidal stepper ramp generator. Moves are planned
// and stepped by an in-bench ramp predictor; every result transfer is
// compared field by field against the oldest predicted result, under random
// idling on both streams outside one gap-free phase, and several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic        kind;
        logic [31:0] steps;
        logic [15:0] accel;
        logic [15:0] decel;
        logic [15:0] speed;
        logic        hold;
    } t_move_item;

    typedef struct packed {
        logic        accepted;
        logic [30:0] offset;
        logic        step_done;
        logic        dir;
        logic [31:0] pos;
        logic [1:0]  phase;
        logic        moving;
        logic [31:0] total;
    } t_ramp_result;

    typedef struct packed {
        t_move_item   item;
        t_ramp_result res;
    } t_pending;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [87:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_addr = '0;
    logic [31:0]  i_cfg_wdata = '0;

    stepper_trapezoid_ramp u_top (.*);

    // ramp predictor state and registers
    logic [31:0] k_speed_time, k_c0_sq;
    logic [15:0] k_c0_freq, k_accel_lim;
    logic [1:0]  rp_phase;
    logic        rp_dir, rp_half, rp_busy;
    logic [31:0] rp_delay, rp_min_delay, rp_decel_at, rp_decel_len, rp_index;
    logic [31:0] rp_rem, rp_steps, rp_last_delay, rp_pos, rp_total;

    t_pending     move_q[$];
    t_ramp_result ramp_exp_q[$];
    t_ramp_result drv_res;
    int           mismatches = 0;
    int           idle_cycles = 0;
    bit           no_gaps = 1'b0;
    bit           rx_hold_req = 1'b0;
    bit           rx_hold_seen = 1'b0;
    int           rx_hold_cnt = 0;
    int           tx_gap = 0;
    int           rx_wait = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] next_ramp_delay();
        longint d, m, q, r;
        d = 2 * longint'({32'd0, rp_delay}) + longint'({32'd0, rp_rem});
        m = 4 * longint'($signed(rp_index)) + 1;
        q = d / m;
        r = d % m;
        rp_rem = (r > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
        return (rp_delay - q[31:0]) & str_pkg::DelayMask;
    endfunction

    function automatic void count_step();
        rp_total++;
        rp_steps++;
        rp_pos = rp_dir ? rp_pos - 32'd1 : rp_pos + 32'd1;
    endfunction

    function automatic bit plan_move(t_move_item it);
        logic [31:0] mag;
        longint unsigned lim_div, c0, smax, alim, dmag;
        mag = it.steps[31] ? -it.steps : it.steps;
        if (rp_busy) return 1'b0;
        if (mag >= 2) begin
            lim_div = (64'(k_accel_lim) * 64'(it.accel)) / 10;
            if (it.speed == 0 || it.accel == 0 || it.decel == 0 || lim_div == 0)
                return 1'b0;
            rp_min_delay = k_speed_time / 32'(it.speed);
            c0 = int_sqrt(64'(k_c0_freq) * 64'(k_c0_freq) *
                          64'(k_c0_sq / 32'(it.accel))) / 10;
            smax = (64'(it.speed) * 64'(it.speed)) / lim_div;
            if (smax == 0) smax = 1;
            alim = (64'(mag) * 64'(it.decel)) / (64'(it.accel) + 64'(it.decel));
            if (alim == 0) alim = 1;
            if (alim <= smax) dmag = 64'(mag) - alim;
            else dmag = (smax * 64'(it.accel)) / 64'(it.decel);
            if (dmag == 0) dmag = 1;
            rp_decel_len = -dmag[31:0];
            rp_decel_at = mag - dmag[31:0];
            if (c0 <= 64'(rp_min_delay)) begin
                rp_delay = rp_min_delay;
                rp_last_delay = rp_min_delay & str_pkg::DelayMask;
                rp_phase = str_pkg::PH_RUN;
            end else begin
                rp_delay = c0[31:0];
                rp_phase = str_pkg::PH_ACCEL;
            end
            rp_index = 0;
        end else if (mag == 1) begin
            rp_index = 32'hFFFF_FFFF;
            rp_phase = str_pkg::PH_DECEL;
            rp_delay = 32'd1000;
        end
        rp_dir = it.steps[31];
        rp_busy = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit advance_ramp(logic hold);
        logic [31:0] nd;
        bit stepped;
        stepped = 1'b0;
        nd = rp_delay;
        rp_half = ~rp_half;
        if (rp_half) return 1'b0;
        case (rp_phase)
            str_pkg::PH_STOP: begin
                rp_steps = 0;
                rp_rem = 0;
                rp_busy = 1'b0;
            end
            str_pkg::PH_ACCEL: begin
                count_step();
                stepped = 1'b1;
                rp_index++;
                nd = next_ramp_delay();
                if (rp_steps >= rp_decel_at) begin
                    rp_index = rp_decel_len;
                    rp_phase = str_pkg::PH_DECEL;
                end else if (nd <= rp_min_delay) begin
                    rp_last_delay = nd;
                    nd = rp_min_delay & str_pkg::DelayMask;
                    rp_rem = 0;
                    rp_phase = str_pkg::PH_RUN;
                end
            end
            str_pkg::PH_RUN: begin
                if (!hold) begin
                    count_step();
                    stepped = 1'b1;
                    nd = rp_min_delay & str_pkg::DelayMask;
                    if (rp_steps >= rp_decel_at) begin
                        rp_index = rp_decel_len;
                        nd = rp_last_delay;
                        rp_phase = str_pkg::PH_DECEL;
                    end
                end
            end
            default: begin
                count_step();
                stepped = 1'b1;
                rp_index++;
                nd = next_ramp_delay();
                if (!rp_index[31]) rp_phase = str_pkg::PH_STOP;
            end
        endcase
        rp_delay = nd;
        return stepped;
    endfunction

    function automatic t_ramp_result predict_ramp(t_move_item it);
        t_ramp_result r;
        r = '0;
        if (!it.kind) begin
            if (plan_move(it)) begin
                r.accepted = 1'b1;
                r.offset = rp_delay[31:1];
            end
        end else if (rp_busy) begin
            r.offset = rp_delay[31:1];
            r.step_done = advance_ramp(it.hold);
        end
        r.dir = rp_dir;
        r.pos = rp_pos;
        r.phase = rp_phase;
        r.moving = rp_busy;
        r.total = rp_total;
        return r;
    endfunction

    task automatic queue_item(t_move_item it);
        t_pending p;
        p.item = it;
        p.res = predict_ramp(it);
        move_q.push_back(p);
    endtask

    task automatic queue_event(logic hold);
        t_move_item it;
        it = {1'b1, 32'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), hold};
        queue_item(it);
    endtask

    task automatic queue_cmd(logic [31:0] steps, logic [15:0] acc, logic [15:0] dec,
                             logic [15:0] spd);
        queue_item({1'b0, steps, acc, dec, spd, 1'($urandom)});
    endtask

    function automatic logic [15:0] pick_rate();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'd0;
        if (r < 8) return 16'($urandom_range(1, 64));
        if (r < 11) return 16'hFFFF;
        return 16'($urandom_range(1, 65535));
    endfunction

    task automatic queue_move();
        logic [31:0] mag;
        int unsigned r, n;
        r = $urandom_range(0, 9);
        if (r == 0) mag = $urandom_range(0, 1);
        else if (r < 8) mag = $urandom_range(2, 40);
        else mag = $urandom_range(41, 150);
        queue_cmd($urandom_range(0, 1) ? -mag : mag, pick_rate(), pick_rate(), pick_rate());
        n = 0;
        while (rp_busy && n < 1500) begin
            if ($urandom_range(0, 15) == 0)
                queue_cmd($urandom, pick_rate(), pick_rate(), pick_rate());
            queue_event($urandom_range(0, 4) == 0);
            n++;
        end
        repeat ($urandom_range(0, 1)) queue_event(1'($urandom));
    endtask

    task automatic wait_drained();
        wait (move_q.size() == 0 && !s_axis_tvalid && ramp_exp_q.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_registers(logic [31:0] spd_t, logic [15:0] freq, logic [31:0] sq,
                                   logic [15:0] lim);
        logic [31:0] vals[4];
        vals = '{spd_t, 32'(freq), sq, 32'(lim)};
        for (int i = 0; i < 4; i++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_addr <= 2'(i);
            i_cfg_wdata <= vals[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        k_speed_time = spd_t;
        k_c0_freq = freq;
        k_c0_sq = sq;
        k_accel_lim = lim;
    endtask

    // driver
    always @(posedge i_clk) begin
        t_pending p;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) ramp_exp_q.push_back(drv_res);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end else if (move_q.size() > 0) begin
                    p = move_q.pop_front();
                    drv_res <= p.res;
                    s_axis_tuser <= p.item.kind;
                    s_axis_tdata <= {7'd0, p.item.hold, p.item.speed, p.item.decel,
                                     p.item.accel, p.item.steps};
                    s_axis_tvalid <= 1'b1;
                    tx_gap <= no_gaps ? 0 : $urandom_range(0, 17);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_ramp_result got, want;
        int w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[0], m_axis_tdata[31:1], m_axis_tdata[32],
                       m_axis_tdata[33], m_axis_tdata[65:34], m_axis_tdata[67:66],
                       m_axis_tdata[68], m_axis_tdata[100:69]};
                if (ramp_exp_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result transfer %p", got);
                end else begin
                    want = ramp_exp_q.pop_front();
                    if (got.accepted != want.accepted || got.offset != want.offset ||
                        got.step_done != want.step_done || got.dir != want.dir ||
                        got.pos != want.pos || got.phase != want.phase ||
                        got.moving != want.moving || got.total != want.total) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (rx_hold_req && !rx_hold_seen) begin
                rx_hold_seen <= 1'b1;
                rx_hold_cnt <= 3000;
                m_axis_tready <= 1'b0;
            end else if (rx_hold_cnt > 0) begin
                rx_hold_cnt <= rx_hold_cnt - 1;
                m_axis_tready <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                w = no_gaps ? 0 : $urandom_range(0, 17);
                rx_wait <= w;
                m_axis_tready <= (w == 0);
            end else if (rx_wait > 0) begin
                rx_wait <= rx_wait - 1;
                m_axis_tready <= (rx_wait == 1);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("stepper_trapezoid_ramp regression: fail");
            $finish;
        end
    end

    initial begin
        int made;
        k_speed_time = 32'd1000000;
        k_c0_freq = 16'd676;
        k_c0_sq = 32'd6283;
        k_accel_lim = 16'd63;
        rp_phase = str_pkg::PH_STOP;
        {rp_dir, rp_half, rp_busy} = '0;
        {rp_delay, rp_min_delay, rp_decel_at, rp_decel_len, rp_index} = '0;
        {rp_rem, rp_steps, rp_last_delay, rp_pos, rp_total} = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle event, zero and one step moves, busy and divisor rejects
        queue_event(1'b1);
        queue_cmd(32'd0, 16'd100, 16'd100, 16'd100);
        queue_event(1'b0);
        queue_event(1'b1);
        queue_cmd(32'hFFFF_FFFF, 16'd100, 16'd100, 16'd100);
        queue_event(1'b0);
        queue_event(1'b0);
        queue_cmd(32'd3, 16'd1, 16'd1, 16'd1);
        queue_cmd(32'h8000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_cmd(32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        while (rp_busy) queue_event(1'b0);
        queue_cmd(32'h8000_0000, 16'd0, 16'hFFFF, 16'hFFFF);
        queue_cmd(32'h7FFF_FFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        queue_cmd(32'd5, 16'hFFFF, 16'hFFFF, 16'd0);
        queue_cmd(32'd5, 16'd1, 16'd1, 16'd1);
        while (rp_busy) queue_event(1'($urandom_range(0, 1)));
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_registers(32'd1000000, 16'd676, 32'd6283, 16'd63);
                1: write_registers(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
                2: write_registers(32'd1, 16'd1, 32'd1, 16'd1);
                3: write_registers($urandom_range(1, 32'hFFFF_FFFF),
                                   16'($urandom_range(1, 65535)),
                                   $urandom_range(1, 32'hFFFF_FFFF),
                                   16'($urandom_range(1, 65535)));
                default: write_registers(32'd1000000, 16'd676, 32'd6283, 16'd63);
            endcase
            no_gaps = (ph == 3);
            if (ph == 1) rx_hold_req <= 1'b1;
            made = 0;
            while (made < 320) begin
                made -= move_q.size();
                queue_move();
                made += move_q.size();
                if (ph == 0 && made > 150 && made < 200) wait_drained();
            end
            wait_drained();
        end

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && ramp_exp_q.size() == 0)
            $display("stepper_trapezoid_ramp regression: pass");
        else
            $display("stepper_trapezoid_ramp regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/str_pkg.sv
design/str_alu.sv
design/stepper_trapezoid_ramp.sv
design/str_chk.sv
sim/tb.sv
